// File: rtl/core/ctt_pkg.sv
// ctt_pkg: shared types and codes of the can id traffic table
// no dependencies; used by ctt_front, ctt_back and the top level

package ctt_pkg;

    // longest stored payload in bytes
    localparam int LEN_MAX     = 8;
    // items held between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        STATUS_HIT  = 2'd0,
        STATUS_NEW  = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELTA,
        ST_WRITE
    } t_state;

    // classified frame as it travels from front to back
    typedef struct packed {
        logic [28:0] frame_id;
        logic        bus_side;
        logic [3:0]  length;
        logic [7:0]  byte_en;
        logic [63:0] payload;
        logic        fwd;
        logic [31:0] time_ms;
    } t_item;

    // head of the item queue
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // one table record
    typedef struct packed {
        logic [28:0] ident;
        logic        bus;
        logic [31:0] count;
        logic [15:0] period;
        logic [31:0] last_time;
        logic [3:0]  length;
        logic [63:0] bytes;
        logic        fwd;
    } t_rec;

endpackage

// File: rtl/core/ctt_ram.sv
// ctt_ram: generic single write port ram with registered read
// no dependencies

module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ctt_front.sv
// ctt_front: accepts frames, clamps length, builds byte enables, queues items
// depends on ctt_pkg

module ctt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [28:0]       i_frame_id,
    input  logic              i_bus_side,
    input  logic [7:0]        i_byte_count,
    input  logic [63:0]       i_payload,
    input  logic              i_was_forwarded,
    input  logic [31:0]       i_time_ms,
    output ctt_pkg::t_qhead   o_head,
    input  logic              i_pop
);

    localparam int QPW = (ctt_pkg::QUEUE_DEPTH > 1) ? $clog2(ctt_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(ctt_pkg::QUEUE_DEPTH + 1);

    ctt_pkg::t_item w_item;
    ctt_pkg::t_item r_q [ctt_pkg::QUEUE_DEPTH];
    logic [QPW-1:0] r_wp, n_wp;
    logic [QPW-1:0] r_rp, n_rp;
    logic [QCW-1:0] r_cnt, n_cnt;
    logic           w_push;
    logic           w_pop;

    // classify: clamp length and expand it to byte enables
    always_comb begin
        w_item          = '0;
        w_item.frame_id = i_frame_id;
        w_item.bus_side = i_bus_side;
        w_item.payload  = i_payload;
        w_item.fwd      = i_was_forwarded;
        w_item.time_ms  = i_time_ms;
        if (i_byte_count > 8'(ctt_pkg::LEN_MAX)) begin
            w_item.length = 4'(ctt_pkg::LEN_MAX);
        end else begin
            w_item.length = i_byte_count[3:0];
        end
        for (int b = 0; b < ctt_pkg::LEN_MAX; b++) begin
            w_item.byte_en[b] = (4'(b) < w_item.length);
        end
    end

    assign o_in_stall = (r_cnt == QCW'(ctt_pkg::QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QPW'(ctt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == QPW'(ctt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

// File: rtl/core/ctt_back.sv
// ctt_back: scans the record table, updates the matching or a newly claimed slot (none when full), holds the result
// depends on ctt_pkg and ctt_ram

module ctt_back #(
    parameter int SLOTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctt_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_status,
    output logic [5:0]      o_slot_index,
    output logic [31:0]     o_seen_count,
    output logic [15:0]     o_period_ms
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = $bits(ctt_pkg::t_rec);

    ctt_pkg::t_state  r_state, n_state;
    ctt_pkg::t_item   r_item, n_item;
    ctt_pkg::t_rec    r_rec, n_rec;
    ctt_pkg::t_rec    w_rd;
    ctt_pkg::t_rec    w_wdata;
    ctt_pkg::t_status r_status, n_status;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_fill, n_fill;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [AW-1:0]    r_slot, n_slot;
    logic [31:0]      r_dt, n_dt;
    logic [17:0]      r_tri, n_tri;
    logic [31:0]      w_sum;
    logic [15:0]      w_period;
    logic             w_match;
    logic             w_we;
    logic [AW-1:0]    w_raddr;

    logic             r_out_valid, n_out_valid;
    ctt_pkg::t_status r_out_status, n_out_status;
    logic [5:0]       r_out_slot, n_out_slot;
    logic [31:0]      r_out_count, n_out_count;
    logic [15:0]      r_out_period, n_out_period;

    ctt_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_match = r_pend && (w_rd.ident == r_item.frame_id) && (w_rd.bus == r_item.bus_side);
    assign w_sum   = 32'(r_tri) + r_dt;

    // period: kept with no earlier frame, first interval taken as is, then smoothed
    always_comb begin
        if (r_rec.last_time == '0) begin
            w_period = r_rec.period;
        end else if (r_rec.period == '0) begin
            w_period = r_dt[15:0];
        end else begin
            w_period = w_sum[17:2];
        end
    end

    // updated record
    always_comb begin
        w_wdata           = r_rec;
        w_wdata.ident     = r_item.frame_id;
        w_wdata.bus       = r_item.bus_side;
        w_wdata.count     = r_rec.count + 32'd1;
        w_wdata.period    = w_period;
        w_wdata.last_time = r_item.time_ms;
        w_wdata.length    = r_item.length;
        w_wdata.fwd       = r_item.fwd;
        for (int b = 0; b < ctt_pkg::LEN_MAX; b++) begin
            if (r_item.byte_en[b]) begin
                w_wdata.bytes[8*b +: 8] = r_item.payload[8*b +: 8];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_rec        = r_rec;
        n_status     = r_status;
        n_idx        = r_idx;
        n_fill       = r_fill;
        n_pend       = r_pend;
        n_paddr      = r_paddr;
        n_slot       = r_slot;
        n_dt         = r_dt;
        n_tri        = r_tri;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_count  = r_out_count;
        n_out_period = r_out_period;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_raddr      = r_idx[AW-1:0];
        case (r_state)
            ctt_pkg::ST_IDLE: begin
                if (i_head.valid && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_head.item;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = ctt_pkg::ST_SCAN;
                end
            end
            ctt_pkg::ST_SCAN: begin
                if (w_match) begin
                    n_slot   = r_paddr;
                    n_rec    = w_rd;
                    n_status = ctt_pkg::STATUS_HIT;
                    n_state  = ctt_pkg::ST_DELTA;
                end else if (r_idx < r_fill) begin
                    // issue next read while comparing the previous one
                    n_pend  = 1'b1;
                    n_paddr = r_idx[AW-1:0];
                    n_idx   = r_idx + 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (r_fill < CW'(SLOTS)) begin
                    // used slots always form a prefix, so the first free one is the fill
                    n_slot   = r_fill[AW-1:0];
                    n_rec    = '0;
                    n_status = ctt_pkg::STATUS_NEW;
                    n_fill   = r_fill + 1'b1;
                    n_state  = ctt_pkg::ST_DELTA;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_status = ctt_pkg::STATUS_FULL;
                    n_out_slot   = '0;
                    n_out_count  = '0;
                    n_out_period = '0;
                    n_state      = ctt_pkg::ST_IDLE;
                end
            end
            ctt_pkg::ST_DELTA: begin
                n_dt    = r_item.time_ms - r_rec.last_time;
                n_tri   = {1'b0, r_rec.period, 1'b0} + {2'b00, r_rec.period};
                n_state = ctt_pkg::ST_WRITE;
            end
            ctt_pkg::ST_WRITE: begin
                w_we         = 1'b1;
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_slot   = 6'(r_slot);
                n_out_count  = w_wdata.count;
                n_out_period = w_period;
                n_state      = ctt_pkg::ST_IDLE;
            end
            default: begin
                n_state = ctt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctt_pkg::ST_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_rec        <= n_rec;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_paddr      <= n_paddr;
        r_slot       <= n_slot;
        r_dt         <= n_dt;
        r_tri        <= n_tri;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_count  <= n_out_count;
        r_out_period <= n_out_period;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_index = r_out_slot;
    assign o_seen_count = r_out_count;
    assign o_period_ms  = r_out_period;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(SLOTS))
        else $error("fill count beyond table size");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ctt_pkg::STATUS_FULL) |-> (r_fill == CW'(SLOTS)))
        else $error("drop reported with free slots left");

    a_new_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ctt_pkg::STATUS_NEW) |-> (r_out_count == 32'd1))
        else $error("claimed slot does not report a count of one");

    a_new_is_last_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ctt_pkg::STATUS_NEW)
            |-> (r_out_slot == 6'(r_fill - 1'b1)))
        else $error("claimed slot is not the last filled one");

    a_no_start_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctt_pkg::ST_IDLE && r_out_valid) |=> (r_state == ctt_pkg::ST_IDLE))
        else $error("new item started while result still held");

endmodule

// File: rtl/core/can_id_traffic_table.sv
// can_id_traffic_table: per-identifier can frame record table, top level
// depends on ctt_pkg, ctt_front, ctt_back (which holds ctt_ram)
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    frame_id bus_side byte_count payload
//                                                   was_forwarded time_ms
//   out      from block o_out_valid / i_out_stall  status slot_index seen_count period_ms
//
// in the back end an item is picked up, the table is read once per used slot, the read
// pipe drains, then delta and write follow; the longest case is a hit in the last slot
// or a claim of the last free one; a drop on a full table skips delta and write
// the result is then held, and no new item is picked up until it is taken
// the record memory's single read port makes the scan serial; a hit ends the scan early
// used slots always form a prefix, so a fill count stands in for per-slot used bits and
// no clearing pass follows reset
// the front queue holds two items and keeps accepting while the back end scans
// a held result stalls only the back end; the front keeps filling until the queue is full

module can_id_traffic_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [28:0] i_frame_id,
    input  logic        i_bus_side,
    input  logic [7:0]  i_byte_count,
    input  logic [63:0] i_payload,
    input  logic        i_was_forwarded,
    input  logic [31:0] i_time_ms,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_index,
    output logic [31:0] o_seen_count,
    output logic [15:0] o_period_ms
);

    // queue head from front to back, and the pop that frees it
    ctt_pkg::t_qhead w_head;
    logic            w_pop;

    // front: clamp length, build byte enables, queue the item
    ctt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frame_id      (i_frame_id),
        .i_bus_side      (i_bus_side),
        .i_byte_count    (i_byte_count),
        .i_payload       (i_payload),
        .i_was_forwarded (i_was_forwarded),
        .i_time_ms       (i_time_ms),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    // back: scan for a matching slot, claim a free one, update period and record
    ctt_back #(
        .SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_seen_count (o_seen_count),
        .o_period_ms  (o_period_ms)
    );

endmodule

// File: tb/tb_can_id_traffic_table.sv
// tb_can_id_traffic_table: self-checking bench for the can id traffic table
// depends on ctt_pkg and can_id_traffic_table; directed frames first, then keyed random traffic
`timescale 1ns / 1ps

module tb_can_id_traffic_table;

    localparam int SLOTS      = 64;
    localparam int POOL       = 50;      // recurring identifiers in the random part
    localparam int N_RANDOM   = 1030;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int LIMIT      = 700000;  // watchdog in clock cycles

    // one observed frame as offered on the input channel
    typedef struct packed {
        logic [28:0] frame_id;
        logic        bus_side;
        logic [7:0]  byte_count;
        logic [63:0] payload;
        logic        fwd;
        logic [31:0] time_ms;
    } t_frame;

    // one report on the output channel
    typedef struct packed {
        ctt_pkg::t_status status;
        logic [5:0]       slot;
        logic [31:0]      count;
        logic [15:0]      period;
    } t_report;

    // directed row: frame, and a hand-written report where one is typed in
    typedef struct {
        t_frame  frame;
        bit      typed;
        t_report report;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [28:0] i_frame_id = '0;
    logic        i_bus_side = 1'b0;
    logic [7:0]  i_byte_count = '0;
    logic [63:0] i_payload = '0;
    logic        i_was_forwarded = 1'b0;
    logic [31:0] i_time_ms = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [5:0]  o_slot_index;
    logic [31:0] o_seen_count;
    logic [15:0] o_period_ms;

    can_id_traffic_table #(.TABLE_SLOTS(SLOTS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frame_id      (i_frame_id),
        .i_bus_side      (i_bus_side),
        .i_byte_count    (i_byte_count),
        .i_payload       (i_payload),
        .i_was_forwarded (i_was_forwarded),
        .i_time_ms       (i_time_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_seen_count    (o_seen_count),
        .o_period_ms     (o_period_ms)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the record table, all slots marked unused at the start
    logic        rec_used   [SLOTS];
    logic [28:0] rec_ident  [SLOTS];
    logic        rec_bus    [SLOTS];
    logic [31:0] rec_count  [SLOTS];
    logic [15:0] rec_period [SLOTS];
    logic [31:0] rec_last   [SLOTS];
    logic [3:0]  rec_len    [SLOTS];
    logic [63:0] rec_bytes  [SLOTS];
    logic        rec_fwd    [SLOTS];

    t_report     awaited_reports[$];
    t_plan_row   plan_rows[$];
    int          fails = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;     // random gaps and stalls allowed
    bit          hold_req = 1'b0;    // asks the receiver for one long hold-off
    bit          row_typed = 1'b0;   // current item carries a hand-written report
    t_report     row_report;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            rec_used[i]   = 1'b0;
            rec_ident[i]  = '0;
            rec_bus[i]    = 1'b0;
            rec_count[i]  = '0;
            rec_period[i] = '0;
            rec_last[i]   = '0;
            rec_len[i]    = '0;
            rec_bytes[i]  = '0;
            rec_fwd[i]    = 1'b0;
        end
    end

    // records one frame in the shadow table and returns the report it causes
    function automatic t_report log_frame(t_frame f);
        t_report     r;
        int          hit;
        int          free_slot;
        int          s;
        logic [31:0] dt;
        logic [31:0] sum;
        logic [3:0]  len;
        logic [63:0] mask;
        hit = -1;
        free_slot = -1;
        // lowest matching slot wins; otherwise lowest unused one
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0) begin
                if (rec_used[i] && rec_ident[i] == f.frame_id && rec_bus[i] == f.bus_side)
                    hit = i;
                else if (!rec_used[i] && free_slot < 0)
                    free_slot = i;
            end
        end
        if (hit >= 0) begin
            s = hit;
            r.status = ctt_pkg::STATUS_HIT;
        end else if (free_slot >= 0) begin
            s = free_slot;
            r.status = ctt_pkg::STATUS_NEW;
            rec_used[s]   = 1'b1;
            rec_ident[s]  = f.frame_id;
            rec_bus[s]    = f.bus_side;
            rec_count[s]  = '0;
            rec_period[s] = '0;
            rec_last[s]   = '0;
        end else begin
            // table full: nothing stored, report carries zeros
            r.status = ctt_pkg::STATUS_FULL;
            r.slot   = '0;
            r.count  = '0;
            r.period = '0;
            return r;
        end
        // a stored time of zero means no earlier frame, period left alone
        if (rec_last[s] != 32'd0) begin
            dt = f.time_ms - rec_last[s];
            if (rec_period[s] == 16'd0) begin
                rec_period[s] = dt[15:0];
            end else begin
                sum = {16'd0, rec_period[s]} * 32'd3 + dt;
                rec_period[s] = sum[17:2];
            end
        end
        rec_last[s] = f.time_ms;
        len = (f.byte_count > 8'd8) ? 4'd8 : f.byte_count[3:0];
        rec_len[s] = len;
        mask = (len == 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        rec_bytes[s] = (rec_bytes[s] & ~mask) | (f.payload & mask);
        rec_count[s] = rec_count[s] + 32'd1;
        rec_fwd[s]   = f.fwd;
        r.slot   = s[5:0];
        r.count  = rec_count[s];
        r.period = rec_period[s];
        return r;
    endfunction

    task automatic add_row(input logic [28:0] id, input logic bus, input logic [7:0] len,
                           input logic [63:0] pay, input logic fwd, input logic [31:0] tms,
                           input bit typed, input ctt_pkg::t_status st,
                           input logic [5:0] slot, input logic [31:0] cnt,
                           input logic [15:0] per);
        t_plan_row row;
        row.frame  = '{frame_id: id, bus_side: bus, byte_count: len, payload: pay,
                       fwd: fwd, time_ms: tms};
        row.typed  = typed;
        row.report = '{status: st, slot: slot, count: cnt, period: per};
        plan_rows.push_back(row);
    endtask

    // offers one item at a falling edge and returns once it has been taken
    task automatic offer_frame(input t_frame f, input bit typed, input t_report rep);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_frame_id      = f.frame_id;
        i_bus_side      = f.bus_side;
        i_byte_count    = f.byte_count;
        i_payload       = f.payload;
        i_was_forwarded = f.fwd;
        i_time_ms       = f.time_ms;
        row_typed       = typed;
        row_report      = rep;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // input side: predict on every accepted item
    // output side: compare every accepted report with the oldest prediction
    always @(posedge i_clk) begin
        t_frame  seen;
        t_report guess;
        t_report want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen = '{frame_id: i_frame_id, bus_side: i_bus_side, byte_count: i_byte_count,
                     payload: i_payload, fwd: i_was_forwarded, time_ms: i_time_ms};
            guess = log_frame(seen);
            // hand-written reports take the place of the prediction on their rows
            awaited_reports.push_back(row_typed ? row_report : guess);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_reports.size() == 0) begin
                $display("%0t: report with none awaited, status %0d slot %0d", $time,
                         o_status, o_slot_index);
                fails++;
            end else begin
                want = awaited_reports.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_status);
                    fails++;
                end
                if (o_slot_index !== want.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d", $time, want.slot,
                             o_slot_index);
                    fails++;
                end
                if (o_seen_count !== want.count) begin
                    $display("%0t: seen_count expected %0d actual %0d", $time, want.count,
                             o_seen_count);
                    fails++;
                end
                if (o_period_ms !== want.period) begin
                    $display("%0t: period_ms expected %0d actual %0d", $time, want.period,
                             o_period_ms);
                    fails++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin : out_stall_gen
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 19);
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_can_id_traffic_table failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_frame      f;
        t_report     blank;
        logic [28:0] pool_id   [POOL];
        logic        pool_bus  [POOL];
        logic [31:0] pool_time [POOL];
        logic [31:0] pool_gap  [POOL];
        int          k;
        int          sel;
        blank = '{status: ctt_pkg::STATUS_HIT, slot: '0, count: '0, period: '0};

        // directed frames; reports typed in where they follow directly
        // first frame of a key at time zero, so the next one keeps period zero
        add_row(29'd0, 1'b0, 8'd0, 64'd0, 1'b0, 32'd0,
                1, ctt_pkg::STATUS_NEW, 6'd0, 32'd1, 16'd0);
        add_row(29'd0, 1'b0, 8'd3, 64'h1122334455667788, 1'b1, 32'd100,
                1, ctt_pkg::STATUS_HIT, 6'd0, 32'd2, 16'd0);
        // first real interval taken as is, then smoothed
        add_row(29'd0, 1'b0, 8'd9, 64'h0123456789ABCDEF, 1'b0, 32'd150,
                1, ctt_pkg::STATUS_HIT, 6'd0, 32'd3, 16'd50);
        add_row(29'd0, 1'b0, 8'd255, 64'hFEDCBA9876543210, 1'b1, 32'd250,
                1, ctt_pkg::STATUS_HIT, 6'd0, 32'd4, 16'd62);
        // widest identifier, all-ones fields, timestamp wraps on the next frame
        add_row(29'h1FFFFFFF, 1'b1, 8'd255, '1, 1'b1, 32'hFFFFFFFF,
                1, ctt_pkg::STATUS_NEW, 6'd1, 32'd1, 16'd0);
        add_row(29'h1FFFFFFF, 1'b1, 8'd8, 64'h00FF00FF00FF00FF, 1'b0, 32'h0000000F,
                1, ctt_pkg::STATUS_HIT, 6'd1, 32'd2, 16'd16);
        // same identifier on the other bus is a separate key
        add_row(29'h1FFFFFFF, 1'b0, 8'd1, 64'h55, 1'b0, 32'd5,
                1, ctt_pkg::STATUS_NEW, 6'd2, 32'd1, 16'd0);
        add_row(29'd0, 1'b1, 8'd7, 64'hAA, 1'b1, 32'd7,
                1, ctt_pkg::STATUS_NEW, 6'd3, 32'd1, 16'd0);
        add_row(29'h7FF, 1'b0, 8'd8, 64'hDEADBEEFCAFEF00D, 1'b0, 32'd1,
                1, ctt_pkg::STATUS_NEW, 6'd4, 32'd1, 16'd0);
        // interval wider than 16 bits is truncated
        add_row(29'h7FF, 1'b0, 8'd4, 64'h1, 1'b1, 32'h00012346,
                1, ctt_pkg::STATUS_HIT, 6'd4, 32'd2, 16'h2345);
        // time going back by one: sum wraps modulo 2^32
        add_row(29'h7FF, 1'b0, 8'd2, 64'h2, 1'b0, 32'h00012345,
                1, ctt_pkg::STATUS_HIT, 6'd4, 32'd3, 16'h1A73);
        // stored time of zero, then a frame that must leave the period alone
        add_row(29'h7FF, 1'b0, 8'd6, 64'h3, 1'b1, 32'd0,
                0, ctt_pkg::STATUS_HIT, '0, '0, '0);
        add_row(29'h7FF, 1'b0, 8'd5, 64'h4, 1'b0, 32'd500,
                0, ctt_pkg::STATUS_HIT, '0, '0, '0);
        add_row(29'h7FF, 1'b0, 8'd8, 64'h5, 1'b1, 32'd520,
                0, ctt_pkg::STATUS_HIT, '0, '0, '0);
        add_row(29'h1FFFFFFF, 1'b1, 8'd0, 64'h6, 1'b1, 32'h0000FFFF,
                0, ctt_pkg::STATUS_HIT, '0, '0, '0);
        // alternating bit patterns in identifier, payload and time
        add_row(29'h15555555, 1'b1, 8'd8, 64'hAAAAAAAAAAAAAAAA, 1'b1, 32'h80000000,
                1, ctt_pkg::STATUS_NEW, 6'd5, 32'd1, 16'd0);
        add_row(29'h0AAAAAAA, 1'b0, 8'd8, 64'h5555555555555555, 1'b0, 32'h7FFFFFFF,
                1, ctt_pkg::STATUS_NEW, 6'd6, 32'd1, 16'd0);
        add_row(29'h15555555, 1'b1, 8'd8, 64'h5555555555555555, 1'b0, 32'h80000028,
                0, ctt_pkg::STATUS_HIT, '0, '0, '0);

        // recurring keys: half 11-bit, half 29-bit, some with wrapping clocks
        for (int p = 0; p < POOL; p++) begin
            pool_id[p]   = (p % 2 == 0) ? 29'($urandom_range(0, 11'h7FF)) : 29'($urandom);
            pool_bus[p]  = 1'($urandom);
            pool_time[p] = (p % 8 == 0) ? 32'hFFFFFF00 + $urandom_range(0, 255) : $urandom;
            pool_gap[p]  = (p % 5 == 0) ? $urandom_range(1000, 90000) : $urandom_range(1, 200);
        end

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan_rows[r])
            offer_frame(plan_rows[r].frame, plan_rows[r].typed, plan_rows[r].report);

        for (int n = 0; n < N_RANDOM; n++) begin
            // idling comes and goes in phases, none at the tail
            idle_on = (n < N_RANDOM - 150) && ((n / 120) % 3 != 2);
            // block fills while the receiver holds off
            if (n == 200)
                hold_req = 1'b1;
            sel = $urandom_range(0, 99);
            f.payload    = {$urandom, $urandom};
            f.fwd        = 1'($urandom);
            f.byte_count = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8)) : 8'($urandom);
            if (sel < 12) begin
                // unseen key: claims a slot, or is dropped once the table is full
                f.frame_id = 29'($urandom);
                f.bus_side = 1'($urandom);
                f.time_ms  = $urandom;
            end else begin
                k = $urandom_range(0, POOL - 1);
                f.frame_id = pool_id[k];
                f.bus_side = pool_bus[k];
                sel = $urandom_range(0, 99);
                if (sel < 3)
                    f.time_ms = 32'd0;
                else if (sel < 6)
                    f.time_ms = $urandom;
                else
                    f.time_ms = pool_time[k] + pool_gap[k] + $urandom_range(0, 20) - 32'd10;
                pool_time[k] = f.time_ms;
            end
            offer_frame(f, 1'b0, blank);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        row_typed  = 1'b0;

        // drain, then keep watching for stray reports before the verdict
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (SLOTS + 10) @(posedge i_clk);

        if (fails == 0 && awaited_reports.size() == 0)
            $display("tb_can_id_traffic_table passed");
        else
            $display("tb_can_id_traffic_table failed");
        $finish;
    end

endmodule
